/* rtl/core/lbtrt_pkg.sv */
// ----------------------------------------------------------------------------
// lbtrt_pkg
// Shared types, constants and direction tables for the D3Q19 TRT collision core.
// ----------------------------------------------------------------------------
package lbtrt_pkg;

  localparam int POP_W      = 32;
  localparam int FRAC_BITS  = 28;
  localparam int RATE_SHIFT = 30;
  localparam int REG_W      = 32;
  localparam int SUM_W      = 37;
  localparam int NDIR       = 19;
  localparam int DIR_W      = 5;
  localparam int NODE_DEPTH = 2 * NDIR;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 136;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_ANTISYM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SYM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_Z      = 3'd4;

  localparam logic [DIR_W-1:0] DIR_REST = 5'd0;
  localparam logic [DIR_W-1:0] DIR_LAST_AXIS = 5'd6;
  localparam logic [DIR_W-1:0] DIR_LAST = 5'd18;

  // Node summary handed from front to back
  typedef struct packed {
    logic                    bank;
    logic signed [SUM_W-1:0] rho;
    logic signed [SUM_W-1:0] jx;
    logic signed [SUM_W-1:0] jy;
    logic signed [SUM_W-1:0] jz;
  } job_t;

  // Node buffer write request
  typedef struct packed {
    logic                    en;
    logic [NODE_AW-1:0]      addr;
    logic signed [POP_W-1:0] data;
  } node_wr_t;

  // Live configuration
  typedef struct packed {
    logic [REG_W-1:0]        rate_antisym;
    logic [REG_W-1:0]        rate_sym;
    logic signed [REG_W-1:0] force_x;
    logic signed [REG_W-1:0] force_y;
    logic signed [REG_W-1:0] force_z;
  } cfg_t;

  localparam logic signed [1:0] DX [NDIR] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0,
    2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0,
    2'sd0, 2'sd0};
  localparam logic signed [1:0] DY [NDIR] = '{2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0,
    2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1,
    2'sd1, -2'sd1};
  localparam logic signed [1:0] DZ [NDIR] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1,
    -2'sd1, 2'sd1};

  // Map a node slot in one of the two banks to a buffer address
  function automatic logic [NODE_AW-1:0] node_addr(input logic bank,
                                                   input logic [DIR_W-1:0] k);
    logic [NODE_AW-1:0] a;
    a = NODE_AW'(k);
    return bank ? a + NODE_AW'(NDIR) : a;
  endfunction

  // Opposite direction: pairs are (1,2), (3,4), ...
  function automatic logic [DIR_W-1:0] opp_dir(input logic [DIR_W-1:0] k);
    if (k == DIR_REST) return DIR_REST;
    return k[0] ? k + 5'd1 : k - 5'd1;
  endfunction

  // Signed select: +v, -v or zero by a direction component
  function automatic logic signed [SUM_W+2:0] dir_term(input logic signed [SUM_W-1:0] v,
                                                       input logic signed [1:0] d);
    logic signed [SUM_W+2:0] e;
    e = (SUM_W+3)'(v);
    if (d == 2'sd1) return e;
    if (d == -2'sd1) return -e;
    return '0;
  endfunction

  // Clamp a wide signed value to the population range
  function automatic logic signed [POP_W-1:0] sat_pop(input logic signed [55:0] v);
    logic signed [55:0] hi;
    logic signed [55:0] lo;
    hi = 56'((64'sd1 <<< (POP_W - 1)) - 64'sd1);
    lo = -hi - 56'sd1;
    if (v > hi) return POP_W'(hi);
    if (v < lo) return POP_W'(lo);
    return POP_W'(v);
  endfunction

endpackage

/* rtl/core/lattice_boltzmann_trt_collision_core.sv */
// ----------------------------------------------------------------------------
// lattice_boltzmann_trt_collision_core
// D3Q19 two-relaxation-time collision with body force for one node at a time.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  in_*     | input     | population (Q4.28)
//  out_*    | output    | direction, post_value, momentum x/y/z; tlast = last
//  cfg_*    | input     | register index, write data
//
//  The front takes one population per cycle into a two-bank node buffer.
//  The back takes each direction through read, operands, multiply, sum,
//  combine, two divide-by-nine steps and output, one direction at a time.
//  Up to two nodes may be pending; input stalls while both banks are owned.
//  Reset is synchronous; a stall on the output holds the back part only.
// ----------------------------------------------------------------------------
module lattice_boltzmann_trt_collision_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [31:0]             in_tdata,   // [31:0] population
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [135:0]            out_tdata,  // [4:0] direction, [36:5] post_value,
                                              // [68:37] momentum_x, [100:69] momentum_y,
                                              // [132:101] momentum_z, rest zero
  output logic                    out_tlast,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import lbtrt_pkg::*;

  cfg_t     cfg_r;
  node_wr_t node_wr;
  job_t     push_job, head_job;
  logic     job_push, job_pop, job_release, head_valid;
  logic [NODE_AW-1:0]      raddr_k, raddr_o;
  logic signed [POP_W-1:0] rdata_k, rdata_o;
  logic [DIR_W-1:0]        o_dir;
  logic signed [POP_W-1:0] o_post, o_mx, o_my, o_mz;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_antisym <= 32'h4000_0000;
      cfg_r.rate_sym     <= 32'h4000_0000;
      cfg_r.force_x      <= '0;
      cfg_r.force_y      <= '0;
      cfg_r.force_z      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_ANTISYM: cfg_r.rate_antisym <= cfg_wdata;
        REG_RATE_SYM:     cfg_r.rate_sym     <= cfg_wdata;
        REG_FORCE_X:      cfg_r.force_x      <= cfg_wdata;
        REG_FORCE_Y:      cfg_r.force_y      <= cfg_wdata;
        REG_FORCE_Z:      cfg_r.force_z      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lbtrt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_pop      (in_tdata),
    .node_wr     (node_wr),
    .job_push    (job_push),
    .job         (push_job),
    .job_release (job_release)
  );

  // Two copies of the node buffer: one read for each direction of a pair
  lbtrt_ram #(.WIDTH(POP_W), .DEPTH(NODE_DEPTH)) u_ram_k (
    .clk, .we(node_wr.en), .waddr(node_wr.addr), .wdata(node_wr.data),
    .raddr(raddr_k), .rdata(rdata_k)
  );

  lbtrt_ram #(.WIDTH(POP_W), .DEPTH(NODE_DEPTH)) u_ram_o (
    .clk, .we(node_wr.en), .waddr(node_wr.addr), .wdata(node_wr.data),
    .raddr(raddr_o), .rdata(rdata_o)
  );

  lbtrt_queue u_queue (
    .clk, .rst_n,
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lbtrt_back u_back (
    .clk, .rst_n,
    .cfg         (cfg_r),
    .job_valid   (head_valid),
    .job_in      (head_job),
    .job_pop     (job_pop),
    .job_release (job_release),
    .raddr_k, .raddr_o, .rdata_k, .rdata_o,
    .out_tvalid, .out_tready,
    .out_dir     (o_dir),
    .out_post    (o_post),
    .out_last    (out_tlast),
    .out_mx      (o_mx),
    .out_my      (o_my),
    .out_mz      (o_mz)
  );

  assign out_tdata = {3'b000, o_mz, o_my, o_mx, o_post, o_dir};

endmodule

/* rtl/core/lbtrt_ram.sv */
// ----------------------------------------------------------------------------
// lbtrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbtrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lbtrt_front.sv */
// ----------------------------------------------------------------------------
// lbtrt_front
// Accepts populations, buffers them per bank and sums density and momentum.
// ----------------------------------------------------------------------------
module lbtrt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic signed [lbtrt_pkg::POP_W-1:0] in_pop,
  output lbtrt_pkg::node_wr_t               node_wr,
  output logic                              job_push,
  output lbtrt_pkg::job_t                   job,
  input  logic                              job_release
);
  import lbtrt_pkg::*;

  logic [DIR_W-1:0]        fill_r;
  logic                    bank_r;
  logic [1:0]              busy_r;
  logic signed [SUM_W-1:0] rho_r, jx_r, jy_r, jz_r;
  logic signed [SUM_W-1:0] rho_nxt, jx_nxt, jy_nxt, jz_nxt;
  logic                    acc;
  logic signed [SUM_W-1:0] fe;

  // Two banks: hold input while both are owned by pending nodes
  assign in_tready = (busy_r != 2'd2);
  assign acc       = in_tvalid && in_tready;
  assign fe        = SUM_W'(in_pop);

  assign node_wr.en   = acc;
  assign node_wr.addr = node_addr(bank_r, fill_r);
  assign node_wr.data = in_pop;

  always_comb begin
    rho_nxt = rho_r + fe;
    jx_nxt  = jx_r + SUM_W'(dir_term(fe, DX[fill_r]));
    jy_nxt  = jy_r + SUM_W'(dir_term(fe, DY[fill_r]));
    jz_nxt  = jz_r + SUM_W'(dir_term(fe, DZ[fill_r]));
  end

  assign job_push = acc && (fill_r == DIR_LAST);
  assign job.bank = bank_r;
  assign job.rho  = rho_nxt;
  assign job.jx   = jx_nxt;
  assign job.jy   = jy_nxt;
  assign job.jz   = jz_nxt;

  // Advance fill position and sums; clear at node end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= 1'b0;
      rho_r  <= '0;
      jx_r   <= '0;
      jy_r   <= '0;
      jz_r   <= '0;
    end else if (acc) begin
      if (fill_r == DIR_LAST) begin
        fill_r <= '0;
        bank_r <= ~bank_r;
        rho_r  <= '0;
        jx_r   <= '0;
        jy_r   <= '0;
        jz_r   <= '0;
      end else begin
        fill_r <= fill_r + 5'd1;
        rho_r  <= rho_nxt;
        jx_r   <= jx_nxt;
        jy_r   <= jy_nxt;
        jz_r   <= jz_nxt;
      end
    end
  end

  // Count banks owned by nodes not yet fully emitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (job_push && !job_release) begin
      busy_r <= busy_r + 2'd1;
    end else if (!job_push && job_release) begin
      busy_r <= busy_r - 2'd1;
    end
  end

endmodule

/* rtl/core/lbtrt_queue.sv */
// ----------------------------------------------------------------------------
// lbtrt_queue
// Two-entry queue of node summaries between front and back.
// ----------------------------------------------------------------------------
module lbtrt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lbtrt_pkg::job_t push_job,
  input  logic            pop,
  output logic            head_valid,
  output lbtrt_pkg::job_t head_job
);
  import lbtrt_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = slot_r[rp_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (!push && pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

/* rtl/core/lbtrt_back.sv */
// ----------------------------------------------------------------------------
// lbtrt_back
// Sequences the 19 directions of a node through TRT collision and emits beats.
// ----------------------------------------------------------------------------
module lbtrt_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lbtrt_pkg::cfg_t                      cfg,
  input  logic                                 job_valid,
  input  lbtrt_pkg::job_t                      job_in,
  output logic                                 job_pop,
  output logic                                 job_release,
  output logic [lbtrt_pkg::NODE_AW-1:0]        raddr_k,
  output logic [lbtrt_pkg::NODE_AW-1:0]        raddr_o,
  input  logic signed [lbtrt_pkg::POP_W-1:0]   rdata_k,
  input  logic signed [lbtrt_pkg::POP_W-1:0]   rdata_o,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lbtrt_pkg::DIR_W-1:0]          out_dir,
  output logic signed [lbtrt_pkg::POP_W-1:0]   out_post,
  output logic                                 out_last,
  output logic signed [lbtrt_pkg::POP_W-1:0]   out_mx,
  output logic signed [lbtrt_pkg::POP_W-1:0]   out_my,
  output logic signed [lbtrt_pkg::POP_W-1:0]   out_mz
);
  import lbtrt_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD   = 9'b000000010,
    ST_OPS  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_SUM  = 9'b000010000,
    ST_NSUM = 9'b000100000,
    ST_DIV1 = 9'b001000000,
    ST_DIV2 = 9'b010000000,
    ST_PUSH = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  job_t               job_r;
  logic [DIR_W-1:0]   k_r;

  logic signed [47:0] a_r, s_r, f_r, fk36_r;
  logic signed [58:0] pa_hi_r, ps_hi_r;
  logic signed [55:0] pa_lo_r, ps_lo_r;
  logic signed [50:0] pm_hi_r [3];
  logic signed [50:0] pm_lo_r [3];
  logic signed [50:0] ta_r, ts_r;
  logic signed [POP_W-1:0] mom_r [3];
  logic [55:0]        m_r;
  logic               neg_r;
  logic [3:0]         rem_r;
  logic [55:0]        q_r;

  logic               can_push;

  // Radix-16 long division step by nine
  function automatic logic [7:0] div9_step(input logic [3:0] rem, input logic [3:0] nib);
    logic [7:0] t;
    logic [3:0] qd;
    t  = {rem, nib};
    qd = '0;
    for (int i = 1; i < 16; i++) begin
      if (t >= 8'(9 * i)) qd = 4'(i);
    end
    return {qd, 4'(t - 8'(qd) * 8'd9)};
  endfunction

  assign raddr_k = node_addr(job_r.bank, k_r);
  assign raddr_o = node_addr(job_r.bank, opp_dir(k_r));

  assign can_push    = !out_tvalid || out_tready;
  assign job_pop     = (state_r == ST_IDLE) && job_valid;
  assign job_release = (state_r == ST_PUSH) && can_push && (k_r == DIR_LAST);

  // Sequence one direction at a time
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_OPS;
      ST_OPS:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_NSUM;
      ST_NSUM: state_nxt = ST_DIV1;
      ST_DIV1: state_nxt = ST_DIV2;
      ST_DIV2: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (can_push) state_nxt = (k_r == DIR_LAST) ? ST_IDLE : ST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (job_pop) k_r <= '0;
      else if (state_r == ST_PUSH && can_push && k_r != DIR_LAST) k_r <= k_r + 5'd1;
    end
  end

  // Latch node summary
  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job_in;
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    logic signed [47:0] fk, fo, diff, sumf, p, fc, rho;
    logic signed [80:0] fa, fs;
    logic signed [68:0] fm;
    logic signed [41:0] y;
    logic signed [55:0] n, x, mv;
    logic [3:0]         rem;
    logic [7:0]         st;
    logic signed [REG_W-1:0] frc [3];
    logic signed [SUM_W-1:0] jv  [3];
    fk   = 48'(rdata_k);
    fo   = 48'(rdata_o);
    diff = fk - fo;
    sumf = fk + fo;
    rho  = 48'(job_r.rho);
    p    = 48'(dir_term(job_r.jx, DX[k_r])) + 48'(dir_term(job_r.jy, DY[k_r]))
         + 48'(dir_term(job_r.jz, DZ[k_r]));
    fc   = 48'(dir_term(SUM_W'(cfg.force_x), DX[k_r]))
         + 48'(dir_term(SUM_W'(cfg.force_y), DY[k_r]))
         + 48'(dir_term(SUM_W'(cfg.force_z), DZ[k_r]));
    frc[0] = cfg.force_x;
    frc[1] = cfg.force_y;
    frc[2] = cfg.force_z;
    jv[0]  = job_r.jx;
    jv[1]  = job_r.jy;
    jv[2]  = job_r.jz;
    case (state_r)
      ST_OPS: begin
        fk36_r <= fk * 48'sd36;
        if (k_r == DIR_REST) begin
          a_r <= '0;
          s_r <= fk * 48'sd36 - rho * 48'sd12;
          f_r <= '0;
        end else if (k_r <= DIR_LAST_AXIS) begin
          a_r <= diff * 48'sd18 - p * 48'sd6;
          s_r <= sumf * 48'sd18 - rho * 48'sd2;
          f_r <= fc * 48'sd6;
        end else begin
          a_r <= diff * 48'sd18 - p * 48'sd3;
          s_r <= sumf * 48'sd18 - rho;
          f_r <= fc * 48'sd3;
        end
      end
      ST_MUL: begin
        pa_hi_r <= 59'($signed(a_r[47:22]) * $signed({1'b0, cfg.rate_antisym}));
        pa_lo_r <= 56'($signed({1'b0, a_r[21:0]}) * $signed({1'b0, cfg.rate_antisym}));
        ps_hi_r <= 59'($signed(s_r[47:22]) * $signed({1'b0, cfg.rate_sym}));
        ps_lo_r <= 56'($signed({1'b0, s_r[21:0]}) * $signed({1'b0, cfg.rate_sym}));
        for (int i = 0; i < 3; i++) begin
          pm_hi_r[i] <= 51'(frc[i] * $signed(job_r.rho[36:18]));
          pm_lo_r[i] <= 51'(frc[i] * $signed({1'b0, job_r.rho[17:0]}));
        end
      end
      ST_SUM: begin
        fa   = (81'(pa_hi_r) <<< 22) + 81'(pa_lo_r);
        fs   = (81'(ps_hi_r) <<< 22) + 81'(ps_lo_r);
        ta_r <= 51'(fa >>> RATE_SHIFT);
        ts_r <= 51'(fs >>> RATE_SHIFT);
        for (int i = 0; i < 3; i++) begin
          fm = (69'(pm_hi_r[i]) <<< 18) + 69'(pm_lo_r[i]);
          y  = 42'(fm >>> FRAC_BITS);
          mom_r[i] <= sat_pop(56'(jv[i]) + 56'((y + 42'sd1) >>> 1));
        end
      end
      ST_NSUM: begin
        n  = 56'(fk36_r) - 56'(ta_r) - 56'(ts_r) + 56'(f_r);
        x  = n + 56'sd18;
        mv = (x < 0) ? (56'sd35 - x) : x;
        neg_r <= (x < 0);
        m_r   <= {2'b00, mv[55:2]};
        rem_r <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        rem = rem_r;
        for (int d = 13; d >= 7; d--) begin
          st = div9_step(rem, (state_r == ST_DIV1) ? m_r[d*4 +: 4] : m_r[(d-7)*4 +: 4]);
          q_r[((state_r == ST_DIV1) ? d : d - 7)*4 +: 4] <= st[7:4];
          rem = st[3:0];
        end
        rem_r <= rem;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == ST_PUSH && can_push) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH && can_push) begin
      out_dir  <= k_r;
      out_post <= sat_pop(neg_r ? -$signed(q_r) : $signed(q_r));
      out_last <= (k_r == DIR_LAST);
      out_mx   <= (k_r == DIR_LAST) ? mom_r[0] : '0;
      out_my   <= (k_r == DIR_LAST) ? mom_r[1] : '0;
      out_mz   <= (k_r == DIR_LAST) ? mom_r[2] : '0;
    end
  end

endmodule
